// ----- rtl/tpd_pkg.sv -----
`timescale 1ns / 1ps

package tpd_pkg;

    localparam int unsigned TICKS_PER_MS = 1000;

    localparam int unsigned DEBOUNCE_W = 10;
    localparam int unsigned STEP_W     = 10;
    localparam int unsigned DELAY_W    = 14;
    localparam int unsigned PULSE_W    = 8;
    localparam int unsigned BLINK_W    = 16;
    localparam int unsigned TICK_W     = 10;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CFG_IDX_W  = 3;

    localparam int unsigned IN_TDATA_W  = 8;
    localparam int unsigned OUT_TDATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE_MS   = 3'd0,
        REG_STEP_US       = 3'd1,
        REG_MAX_DELAY_US  = 3'd2,
        REG_PULSE_US      = 3'd3,
        REG_BLINK_HALF_MS = 3'd4
    } cfg_reg_t;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST  = 10'd50;
    localparam logic [STEP_W-1:0]     STEP_RST      = 10'd100;
    localparam logic [DELAY_W-1:0]    MAX_DELAY_RST = 14'd9000;
    localparam logic [PULSE_W-1:0]    PULSE_RST     = 8'd10;
    localparam logic [BLINK_W-1:0]    BLINK_HALF_RST = 16'd1000;
    localparam logic [DELAY_W-1:0]    DELAY_RST     = 14'd2000;

    localparam logic [TICK_W-1:0]     TICK_WRAP     = TICK_W'(TICKS_PER_MS);
    localparam logic [DEBOUNCE_W-1:0] ELAPSED_MAX   = '1;
    localparam logic [BLINK_W-1:0]    BLINK_ELAPSED_MAX = '1;

endpackage

// ----- rtl/triac_phase_dimmer_with_buttons.sv -----
`timescale 1ns / 1ps

// Phase-angle triac dimmer with two debounced buttons. Each input transaction is one
// microsecond tick (tdata bit 0 zero-cross level, bit 1 darker button, bit 2 brighter
// button); each tick yields exactly one output transaction with the gate level, the
// current firing delay and the blink flag after that tick. The block takes one tick
// per clock cycle unless stalled: one combinational pass updates state and output
// registers, so the result follows in the cycle after acceptance, and a new tick is
// accepted as the previous result is taken. Configuration is written through
// cfg_wr_en/cfg_index/cfg_wdata, by the user only while idle; it is not enforced.
module triac_phase_dimmer_with_buttons
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [tpd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tpd_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // zero_cross, button_darker, button_brighter, zero fill
    input  logic [tpd_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // triac_gate, firing_delay_us, blink_on
    output logic [tpd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
    import tpd_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_DELAY = 2'd1,
        PH_PULSE = 2'd2
    } phase_t;

    // configuration
    logic [DEBOUNCE_W-1:0] debounce_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [DELAY_W-1:0]    max_delay_reg;
    logic [PULSE_W-1:0]    pulse_reg;
    logic [BLINK_W-1:0]    blink_half_reg;

    // state
    logic [DELAY_W-1:0]    delay_reg, delay_next;
    logic                  zc_prev_reg, zc_prev_next;
    phase_t                phase_reg, phase_next;
    logic [DELAY_W-1:0]    cnt_reg, cnt_next;
    logic                  gate_reg, gate_next;
    logic [TICK_W-1:0]     tick_reg, tick_next;
    logic                  dk_last_reg, dk_last_next;
    logic                  br_last_reg, br_last_next;
    logic [DEBOUNCE_W-1:0] dk_elapsed_reg, dk_elapsed_next;
    logic [DEBOUNCE_W-1:0] br_elapsed_reg, br_elapsed_next;
    logic [BLINK_W-1:0]    blink_elapsed_reg, blink_elapsed_next;
    logic                  blink_reg, blink_next;

    logic                  out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    logic                  zc, dk, br;
    logic                  accept;
    logic                  ms_tick;
    logic [TICK_W-1:0]     tick_inc;
    logic [DELAY_W:0]      delay_sum;

    assign zc = s_axis_tdata[0];
    assign dk = s_axis_tdata[1];
    assign br = s_axis_tdata[2];

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_comb
    begin
        tick_inc           = tick_reg + TICK_W'(1);
        delay_sum          = '0;
        ms_tick            = 1'b0;
        tick_next          = tick_inc;
        dk_elapsed_next    = dk_elapsed_reg;
        br_elapsed_next    = br_elapsed_reg;
        blink_elapsed_next = blink_elapsed_reg;
        blink_next         = blink_reg;
        delay_next         = delay_reg;
        dk_last_next       = dk_last_reg;
        br_last_next       = br_last_reg;
        phase_next         = phase_reg;
        cnt_next           = cnt_reg;
        gate_next          = gate_reg;
        zc_prev_next       = zc;

        // millisecond divider
        if (tick_inc >= TICK_WRAP)
        begin
            tick_next = '0;
            ms_tick   = 1'b1;
        end

        if (ms_tick)
        begin
            if (dk_elapsed_reg != ELAPSED_MAX)
            begin
                dk_elapsed_next = dk_elapsed_reg + DEBOUNCE_W'(1);
            end
            if (br_elapsed_reg != ELAPSED_MAX)
            begin
                br_elapsed_next = br_elapsed_reg + DEBOUNCE_W'(1);
            end
            if (blink_elapsed_reg != BLINK_ELAPSED_MAX)
            begin
                blink_elapsed_next = blink_elapsed_reg + BLINK_W'(1);
            end
            if (blink_elapsed_next >= blink_half_reg)
            begin
                blink_next         = !blink_reg;
                blink_elapsed_next = '0;
            end
        end

        // darker button
        if (dk && !dk_last_reg && dk_elapsed_next >= debounce_reg)
        begin
            delay_sum       = {1'b0, delay_reg} + (DELAY_W+1)'(step_reg);
            delay_next      = (delay_sum > {1'b0, max_delay_reg}) ? max_delay_reg
                                                                  : delay_sum[DELAY_W-1:0];
            dk_elapsed_next = '0;
            dk_last_next    = 1'b1;
        end
        else if (!dk && dk_last_reg)
        begin
            dk_last_next = 1'b0;
        end

        // brighter button
        if (br && !br_last_reg && br_elapsed_next >= debounce_reg)
        begin
            delay_next      = (delay_next >= DELAY_W'(step_reg))
                              ? delay_next - DELAY_W'(step_reg) : '0;
            br_elapsed_next = '0;
            br_last_next    = 1'b1;
        end
        else if (!br && br_last_reg)
        begin
            br_last_next = 1'b0;
        end

        // pulse countdown
        unique case (phase_reg)
            PH_PULSE:
            begin
                if (cnt_reg <= DELAY_W'(1))
                begin
                    cnt_next   = '0;
                    gate_next  = 1'b0;
                    phase_next = PH_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg - DELAY_W'(1);
                end
            end
            PH_DELAY: phase_next = PH_DELAY;
            default:  phase_next = PH_IDLE;
        endcase

        // zero-cross edge
        if (phase_next == PH_IDLE && zc && !zc_prev_reg)
        begin
            phase_next = PH_DELAY;
            cnt_next   = delay_next;
        end

        // firing delay countdown
        if (phase_next == PH_DELAY)
        begin
            if (cnt_next == '0)
            begin
                phase_next = PH_PULSE;
                gate_next  = blink_next;
                cnt_next   = DELAY_W'(pulse_reg);
            end
            else
            begin
                cnt_next = cnt_next - DELAY_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg      <= DEBOUNCE_RST;
            step_reg          <= STEP_RST;
            max_delay_reg     <= MAX_DELAY_RST;
            pulse_reg         <= PULSE_RST;
            blink_half_reg    <= BLINK_HALF_RST;
            delay_reg         <= DELAY_RST;
            zc_prev_reg       <= 1'b0;
            phase_reg         <= PH_IDLE;
            cnt_reg           <= '0;
            gate_reg          <= 1'b0;
            tick_reg          <= '0;
            dk_last_reg       <= 1'b0;
            br_last_reg       <= 1'b0;
            dk_elapsed_reg    <= '0;
            br_elapsed_reg    <= '0;
            blink_elapsed_reg <= '0;
            blink_reg         <= 1'b1;
            out_valid_reg     <= 1'b0;
            out_data_reg      <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_DEBOUNCE_MS:   debounce_reg   <= cfg_wdata[DEBOUNCE_W-1:0];
                    REG_STEP_US:       step_reg       <= cfg_wdata[STEP_W-1:0];
                    REG_MAX_DELAY_US:  max_delay_reg  <= cfg_wdata[DELAY_W-1:0];
                    REG_PULSE_US:      pulse_reg      <= cfg_wdata[PULSE_W-1:0];
                    REG_BLINK_HALF_MS: blink_half_reg <= cfg_wdata[BLINK_W-1:0];
                    default: ;
                endcase
            end

            if (accept)
            begin
                delay_reg         <= delay_next;
                zc_prev_reg       <= zc_prev_next;
                phase_reg         <= phase_next;
                cnt_reg           <= cnt_next;
                gate_reg          <= gate_next;
                tick_reg          <= tick_next;
                dk_last_reg       <= dk_last_next;
                br_last_reg       <= br_last_next;
                dk_elapsed_reg    <= dk_elapsed_next;
                br_elapsed_reg    <= br_elapsed_next;
                blink_elapsed_reg <= blink_elapsed_next;
                blink_reg         <= blink_next;
                // result payload
                out_data_reg      <= {blink_next, delay_next, gate_next};
            end

            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule
